/* src/fpsc_pkg.sv */
`default_nettype none
package fpsc_pkg;

  localparam int PLANE_COUNT_DEF = 6;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int CMD_W     = 2;
  localparam int SLOT_W    = 3;
  localparam int COORD_W   = 32;
  localparam int VERDICT_W = 2;
  localparam int PROD_W    = 2 * COORD_W;
  // three products plus the aligned offset, kept exact
  localparam int SUM_W     = PROD_W + 2;
  // distance with the radius added or taken off
  localparam int TEST_W    = SUM_W + 1;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POINT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SPHERE = 2'd2;

  localparam logic [VERDICT_W-1:0] VERDICT_INSIDE    = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_INTERSECT = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE   = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nz;
    logic signed [COORD_W-1:0] off;
  } plane_t;

  // load enables of the stages behind the input register
  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
    logic en5;
  } pipe_en_t;

endpackage
`default_nettype wire

/* src/fpsc_plane_store.sv */
`default_nettype none
module fpsc_plane_store import fpsc_pkg::*; #(
  parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [SLOT_W-1:0] plane_slot,
  input  plane_t            load_plane,
  output plane_t            planes [PLANE_COUNT]
);

  // a slot beyond the table matches no entry and is dropped
  always_ff @(posedge clk) begin
    for (int i = 0; i < PLANE_COUNT; i++) begin
      if (rst) begin
        planes[i] <= '0;
      end else if (load && (32'(plane_slot) == i)) begin
        planes[i] <= load_plane;
      end
    end
  end

endmodule
`default_nettype wire

/* src/fpsc_lane.sv */
`default_nettype none
module fpsc_lane import fpsc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  plane_t                    plane,
  input  logic signed [COORD_W-1:0] px,
  input  logic signed [COORD_W-1:0] py,
  input  logic signed [COORD_W-1:0] pz,
  input  pipe_en_t                  en,
  output logic signed [SUM_W-1:0]   distance
);

  logic signed [PROD_W-1:0] mx;
  logic signed [PROD_W-1:0] my;
  logic signed [PROD_W-1:0] mz;
  logic signed [SUM_W-1:0]  oa;
  logic signed [SUM_W-1:0]  sa;
  logic signed [SUM_W-1:0]  sb;

  // products at 2*FRAC_BITS fraction bits, offset brought to that scale
  always_ff @(posedge clk) begin
    if (en.en2) begin
      mx <= $signed(plane.nx) * $signed(px);
      my <= $signed(plane.ny) * $signed(py);
      mz <= $signed(plane.nz) * $signed(pz);
      oa <= SUM_W'(plane.off) <<< FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (en.en3) begin
      sa <= SUM_W'(mx) + SUM_W'(my);
      sb <= SUM_W'(mz) + oa;
    end
  end

  always_ff @(posedge clk) begin
    if (en.en4) begin
      distance <= sa + sb;
    end
  end

endmodule
`default_nettype wire

/* src/fpsc_verdict.sv */
`default_nettype none
module fpsc_verdict import fpsc_pkg::*; #(
  parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic                    is_sphere,
  input  logic signed [SUM_W-1:0] rs,
  input  logic signed [SUM_W-1:0] distance [PLANE_COUNT],
  output logic [VERDICT_W-1:0]    verdict
);

  logic [PLANE_COUNT-1:0]   hit_out;
  logic [PLANE_COUNT-1:0]   hit_int;
  logic [VERDICT_W-1:0]     verdict_next;

  always_comb begin
    logic signed [TEST_W-1:0] lo_test;
    logic signed [TEST_W-1:0] hi_test;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      lo_test = TEST_W'(distance[i]) + TEST_W'(rs);
      hi_test = TEST_W'(distance[i]) - TEST_W'(rs);
      if (is_sphere) begin
        hit_out[i] = lo_test[TEST_W-1];
        hit_int[i] = hi_test[TEST_W-1];
      end else begin
        hit_out[i] = distance[i][SUM_W-1];
        hit_int[i] = (distance[i] == '0);
      end
    end
  end

  always_comb begin
    if (|hit_out) begin
      verdict_next = VERDICT_OUTSIDE;
    end else if (|hit_int) begin
      verdict_next = VERDICT_INTERSECT;
    end else begin
      verdict_next = VERDICT_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      verdict <= verdict_next;
    end
  end

endmodule
`default_nettype wire

/* src/frustum_point_sphere_classifier.sv */
// channel   dir  signals                          contents
// s_axis    in   tvalid tready tdata[127:0]       coord_x, coord_y, coord_z, extra_value
//                tuser[4:0]                       cmd, plane_slot
// m_axis    out  tvalid tready tdata[7:0]         verdict, zero filled
//
// Five register stages: input, products, partial sums, distance, verdict.
// A test beat is offered on m_axis once it has passed the product, partial-sum,
// distance and verdict registers; one beat per cycle while m_axis_tready stays high.
// Plane loads write the plane table on the accepting edge and give no beat.
// rst (synchronous) empties the pipe and clears every plane to zero.
// A full stage holds while the stage ahead is full and stalled; bubbles close up.
`default_nettype none
module frustum_point_sphere_classifier import fpsc_pkg::*; #(
  parameter int PLANE_COUNT = PLANE_COUNT_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // coord_x, coord_y, coord_z, extra_value
  input  logic [4:0]   s_axis_tuser,   // cmd, plane_slot
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata    // verdict, zero filled
);

  logic [CMD_W-1:0]  cmd;
  logic [SLOT_W-1:0] plane_slot;
  logic              in_acc;
  logic              is_test;
  plane_t            load_plane;
  plane_t            planes [PLANE_COUNT];

  assign cmd        = s_axis_tuser[CMD_W-1:0];
  assign plane_slot = s_axis_tuser[CMD_W+SLOT_W-1:CMD_W];
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign is_test    = (cmd == CMD_POINT) || (cmd == CMD_SPHERE);

  assign load_plane.nx  = s_axis_tdata[31:0];
  assign load_plane.ny  = s_axis_tdata[63:32];
  assign load_plane.nz  = s_axis_tdata[95:64];
  assign load_plane.off = s_axis_tdata[127:96];

  fpsc_plane_store #(.PLANE_COUNT(PLANE_COUNT)) u_store (
    .clk        (clk),
    .rst        (rst),
    .load       (in_acc && (cmd == CMD_LOAD)),
    .plane_slot (plane_slot),
    .load_plane (load_plane),
    .planes     (planes)
  );

  // valid bits and stage readiness
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  pipe_en_t en;

  assign rdy5 = !v5 || m_axis_tready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_axis_tready = rdy1;

  assign en.en2 = rdy2;
  assign en.en3 = rdy3;
  assign en.en4 = rdy4;
  assign en.en5 = rdy5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_acc && is_test;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // input stage
  logic signed [COORD_W-1:0] px1, py1, pz1, ex1;
  logic                      sph1, sph2, sph3, sph4;
  logic signed [SUM_W-1:0]   rs2, rs3, rs4;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      px1  <= s_axis_tdata[31:0];
      py1  <= s_axis_tdata[63:32];
      pz1  <= s_axis_tdata[95:64];
      ex1  <= s_axis_tdata[127:96];
      sph1 <= (cmd == CMD_SPHERE);
    end
  end

  // sphere radius travels beside the lanes at product scale
  always_ff @(posedge clk) begin
    if (en.en2) begin
      rs2  <= SUM_W'(ex1) <<< FRAC_BITS;
      sph2 <= sph1;
    end
    if (en.en3) begin
      rs3  <= rs2;
      sph3 <= sph2;
    end
    if (en.en4) begin
      rs4  <= rs3;
      sph4 <= sph3;
    end
  end

  logic signed [SUM_W-1:0] distance [PLANE_COUNT];

  for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_lane
    fpsc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk      (clk),
      .plane    (planes[g]),
      .px       (px1),
      .py       (py1),
      .pz       (pz1),
      .en       (en),
      .distance (distance[g])
    );
  end

  logic [VERDICT_W-1:0] verdict;

  fpsc_verdict #(.PLANE_COUNT(PLANE_COUNT)) u_verdict (
    .clk       (clk),
    .en        (en.en5),
    .is_sphere (sph4),
    .rs        (rs4),
    .distance  (distance),
    .verdict   (verdict)
  );

  assign m_axis_tvalid = v5;
  assign m_axis_tdata  = {{(8-VERDICT_W){1'b0}}, verdict};

endmodule
`default_nettype wire

/* src/fpsc_checker.sv */
`default_nettype none
module fpsc_checker import fpsc_pkg::*; (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [4:0]   s_axis_tuser,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [7:0]   m_axis_tdata
);

  logic test_in;
  assign test_in = s_axis_tvalid && s_axis_tready
                   && ((s_axis_tuser[CMD_W-1:0] == CMD_POINT)
                       || (s_axis_tuser[CMD_W-1:0] == CMD_SPHERE));

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result beat present straight after reset");

  // a free-running output never back-pressures the input
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled with output ready");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    test_in ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
      ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("test beat did not reach the output in five cycles");

endmodule

bind frustum_point_sphere_classifier fpsc_checker u_fpsc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
